FILE: rtl/mbt_pkg.sv
// types and constants shared by the 3d maze backtracker
package mbt_pkg;

	localparam int NUM_TRIES = 6;
	localparam int DIR_W     = 3;

	// direction codes
	localparam logic [DIR_W-1:0] DIR_PZ = 3'd0;
	localparam logic [DIR_W-1:0] DIR_NZ = 3'd1;
	localparam logic [DIR_W-1:0] DIR_PY = 3'd2;
	localparam logic [DIR_W-1:0] DIR_NY = 3'd3;
	localparam logic [DIR_W-1:0] DIR_PX = 3'd4;
	localparam logic [DIR_W-1:0] DIR_NX = 3'd5;

	// input kinds
	localparam logic OP_START = 1'b0;
	localparam logic OP_STEP  = 1'b1;

	// configuration register indexes
	localparam logic [1:0] CFG_SIZE_X = 2'd0;
	localparam logic [1:0] CFG_SIZE_Y = 2'd1;
	localparam logic [1:0] CFG_SIZE_Z = 2'd2;

	localparam logic [4:0] SIZE_RESET = 5'd8;

	typedef enum logic [1:0] {
		OUT_STARTED  = 2'd0,
		OUT_MOVED    = 2'd1,
		OUT_BACK     = 2'd2,
		OUT_FINISHED = 2'd3
	} outcome_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PROBE,
		ST_CHECK,
		ST_POP,
		ST_REPORT
	} state_t;

	typedef logic [4:0] size_t;

	typedef struct packed {
		size_t x;
		size_t y;
		size_t z;
	} box_t;

	typedef struct packed {
		outcome_t         outcome;
		logic [3:0]       cell_x;
		logic [3:0]       cell_y;
		logic [3:0]       cell_z;
		logic [DIR_W-1:0] moved_dir;
		logic [11:0]      depth;
	} result_t;

endpackage

FILE: rtl/maze_backtracker_3d.sv
// Depth-first 3d maze generator with stream in and out and box size registers.
// Each accepted beat gives exactly one result beat. A step beat is taken in the idle
// state; each direction tried (up to six) then gets a visited-map read and its check,
// a backtrack adds a read of the trail, and a last state hands the result to the
// output register. A start beat and the pass after reset sweep the whole visited-map
// memory of 2^(3*ceil(log2(MAX_DIM))) entries, 4096 at MAX_DIM = 16, one entry per
// cycle, and input is held off during that pass. The output register lets the next
// beat be taken while a result waits.
module maze_backtracker_3d #(
	parameter int MAX_DIM = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // try_first, try_second, try_third, try_fourth,
	                               // try_fifth, try_sixth, zero fill
	input  logic        s_tuser,   // op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // cell_x, cell_y, cell_z, moved_dir, depth, zero fill
	output logic [1:0]  m_tuser,   // outcome
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [4:0]  cfg_data
);

	mbt_pkg::box_t    box_q;
	mbt_pkg::result_t res;
	logic             res_valid, res_ready;
	logic             m_tvalid_q;
	logic [31:0]      m_tdata_q;
	logic [1:0]       m_tuser_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_q.x <= mbt_pkg::SIZE_RESET;
			box_q.y <= mbt_pkg::SIZE_RESET;
			box_q.z <= mbt_pkg::SIZE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				mbt_pkg::CFG_SIZE_X: box_q.x <= cfg_data;
				mbt_pkg::CFG_SIZE_Y: box_q.y <= cfg_data;
				mbt_pkg::CFG_SIZE_Z: box_q.z <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	mbt_walker #(
		.MAX_DIM (MAX_DIM)
	) u_walker (
		.clk       (clk),
		.arst_n    (arst_n),
		.box       (box_q),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_op     (s_tuser),
		.in_tries  (s_tdata[17:0]),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			m_tdata_q <= {5'b0, res.depth, res.moved_dir,
				res.cell_z, res.cell_y, res.cell_x};
			m_tuser_q <= res.outcome;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

FILE: rtl/mbt_ram.sv
// single-port-write, single-port-read synchronous ram with registered read data
module mbt_ram #(
	parameter int DW    = 1,
	parameter int AW    = 12,
	parameter int DEPTH = 4096
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/mbt_walker.sv
// search sequencer with visited map and trail stack memories
module mbt_walker #(
	parameter int MAX_DIM = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  mbt_pkg::box_t         box,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  in_op,
	input  logic [17:0]           in_tries,
	output logic                  res_valid,
	input  logic                  res_ready,
	output mbt_pkg::result_t      res
);

	localparam int CW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int LW    = CW + 1;
	localparam int XW    = (LW > 5) ? LW : 5;
	localparam int AW    = 3 * CW;
	localparam int MDEP  = 1 << AW;
	localparam int CELLS = MAX_DIM * MAX_DIM * MAX_DIM;
	localparam int SAW   = $clog2(CELLS);
	localparam int TW    = $clog2(CELLS + 1);
	localparam int KW    = $clog2(mbt_pkg::NUM_TRIES);
	localparam logic [KW-1:0] K_LAST = KW'(mbt_pkg::NUM_TRIES - 1);

	mbt_pkg::state_t state_q, state_nxt;

	logic [AW-1:0]            clr_addr_q;
	logic                     clr_org_q;
	logic [KW-1:0]            k_q;
	logic [TW-1:0]            top_q;
	logic [CW-1:0]            wx_q, wy_q, wz_q;
	mbt_pkg::outcome_t        outcome_q;
	logic [mbt_pkg::DIR_W-1:0] dir_q;
	logic [mbt_pkg::DIR_W-1:0] tries_q [mbt_pkg::NUM_TRIES];

	logic [CW-1:0] nbx_s1, nby_s1, nbz_s1;
	logic          nb_ok_s1;

	logic [XW-1:0] limx, limy, limz;
	logic [XW-1:0] nbx, nby, nbz;
	logic          nb_ok;
	logic [mbt_pkg::DIR_W-1:0] cur_dir;

	logic          visit_we, visit_wdata, visit_rdata;
	logic [AW-1:0] visit_waddr, visit_raddr;
	logic          stack_we;
	logic [SAW-1:0] stack_waddr, stack_raddr;
	logic [AW-1:0] stack_wdata, stack_rdata;

	logic          accept, clear_last, free_hit, push_go, no_move, pop_go, fin_go;
	logic [TW-1:0] top_dec;

	logic [CW+3:0]  wx_wide, wy_wide, wz_wide;
	logic [TW+11:0] top_wide;

	always_comb begin
		limx = (XW'(box.x) > XW'(MAX_DIM)) ? XW'(MAX_DIM) : XW'(box.x);
		limy = (XW'(box.y) > XW'(MAX_DIM)) ? XW'(MAX_DIM) : XW'(box.y);
		limz = (XW'(box.z) > XW'(MAX_DIM)) ? XW'(MAX_DIM) : XW'(box.z);
	end

	assign cur_dir = tries_q[k_q];

	// neighbour of the walker in the current trial direction
	always_comb begin
		nbx   = XW'(wx_q);
		nby   = XW'(wy_q);
		nbz   = XW'(wz_q);
		nb_ok = 1'b1;
		case (cur_dir)
			mbt_pkg::DIR_PZ: begin
				nbz = XW'(wz_q) + XW'(1);
			end
			mbt_pkg::DIR_NZ: begin
				nbz   = XW'(wz_q) - XW'(1);
				nb_ok = (wz_q != '0);
			end
			mbt_pkg::DIR_PY: begin
				nby = XW'(wy_q) + XW'(1);
			end
			mbt_pkg::DIR_NY: begin
				nby   = XW'(wy_q) - XW'(1);
				nb_ok = (wy_q != '0);
			end
			mbt_pkg::DIR_PX: begin
				nbx = XW'(wx_q) + XW'(1);
			end
			mbt_pkg::DIR_NX: begin
				nbx   = XW'(wx_q) - XW'(1);
				nb_ok = (wx_q != '0);
			end
			default: begin
				nb_ok = 1'b0;
			end
		endcase
		if (nbx >= limx || nby >= limy || nbz >= limz) begin
			nb_ok = 1'b0;
		end
	end

	assign accept     = in_valid && in_ready;
	assign clear_last = (clr_addr_q == '1);
	assign free_hit   = nb_ok_s1 && !visit_rdata;
	assign push_go    = (state_q == mbt_pkg::ST_CHECK) && free_hit && (top_q < TW'(CELLS));
	assign no_move    = (state_q == mbt_pkg::ST_CHECK) && !push_go
		&& (free_hit || k_q == K_LAST);
	assign pop_go     = no_move && (top_q != '0);
	assign fin_go     = no_move && (top_q == '0);
	assign top_dec    = top_q - TW'(1);

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			mbt_pkg::ST_CLEAR: begin
				if (clear_last) begin
					state_nxt = clr_org_q ? mbt_pkg::ST_REPORT : mbt_pkg::ST_IDLE;
				end
			end
			mbt_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_nxt = (in_op == mbt_pkg::OP_START) ? mbt_pkg::ST_CLEAR
						: mbt_pkg::ST_PROBE;
				end
			end
			mbt_pkg::ST_PROBE: begin
				state_nxt = mbt_pkg::ST_CHECK;
			end
			mbt_pkg::ST_CHECK: begin
				if (push_go || fin_go) begin
					state_nxt = mbt_pkg::ST_REPORT;
				end else if (pop_go) begin
					state_nxt = mbt_pkg::ST_POP;
				end else begin
					state_nxt = mbt_pkg::ST_PROBE;
				end
			end
			mbt_pkg::ST_POP: begin
				state_nxt = mbt_pkg::ST_REPORT;
			end
			mbt_pkg::ST_REPORT: begin
				if (res_ready) begin
					state_nxt = mbt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = mbt_pkg::ST_IDLE;
			end
		endcase
	end

	// outputs and memory controls
	always_comb begin
		in_ready    = (state_q == mbt_pkg::ST_IDLE);
		res_valid   = (state_q == mbt_pkg::ST_REPORT);
		visit_we    = 1'b0;
		visit_waddr = {nbz_s1, nby_s1, nbx_s1};
		visit_wdata = 1'b1;
		visit_raddr = {nbz[CW-1:0], nby[CW-1:0], nbx[CW-1:0]};
		stack_we    = push_go;
		stack_waddr = top_q[SAW-1:0];
		stack_wdata = {wz_q, wy_q, wx_q};
		stack_raddr = top_dec[SAW-1:0];
		case (state_q)
			mbt_pkg::ST_CLEAR: begin
				visit_we    = 1'b1;
				visit_waddr = clr_addr_q;
				visit_wdata = clr_org_q && (clr_addr_q == '0);
			end
			mbt_pkg::ST_CHECK: begin
				visit_we = push_go;
			end
			default: begin
				visit_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= mbt_pkg::ST_CLEAR;
			clr_addr_q <= '0;
			clr_org_q  <= 1'b0;
			k_q        <= '0;
			top_q      <= '0;
			wx_q       <= '0;
			wy_q       <= '0;
			wz_q       <= '0;
			outcome_q  <= mbt_pkg::OUT_STARTED;
			dir_q      <= '0;
		end else begin
			state_q <= state_nxt;
			case (state_q)
				mbt_pkg::ST_IDLE: begin
					if (accept) begin
						k_q <= '0;
						if (in_op == mbt_pkg::OP_START) begin
							clr_addr_q <= '0;
							clr_org_q  <= 1'b1;
						end
					end
				end
				mbt_pkg::ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + AW'(1);
					if (clear_last && clr_org_q) begin
						top_q     <= '0;
						wx_q      <= '0;
						wy_q      <= '0;
						wz_q      <= '0;
						outcome_q <= mbt_pkg::OUT_STARTED;
						dir_q     <= '0;
					end
				end
				mbt_pkg::ST_CHECK: begin
					if (push_go) begin
						top_q     <= top_q + TW'(1);
						wx_q      <= nbx_s1;
						wy_q      <= nby_s1;
						wz_q      <= nbz_s1;
						outcome_q <= mbt_pkg::OUT_MOVED;
						dir_q     <= cur_dir;
					end else if (pop_go) begin
						top_q     <= top_dec;
						outcome_q <= mbt_pkg::OUT_BACK;
						dir_q     <= '0;
					end else if (fin_go) begin
						outcome_q <= mbt_pkg::OUT_FINISHED;
						dir_q     <= '0;
					end else begin
						k_q <= k_q + KW'(1);
					end
				end
				mbt_pkg::ST_POP: begin
					wx_q <= stack_rdata[CW-1:0];
					wy_q <= stack_rdata[2*CW-1:CW];
					wz_q <= stack_rdata[3*CW-1:2*CW];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < mbt_pkg::NUM_TRIES; i++) begin
				tries_q[i] <= in_tries[i*mbt_pkg::DIR_W +: mbt_pkg::DIR_W];
			end
		end
		if (state_q == mbt_pkg::ST_PROBE) begin
			nbx_s1   <= nbx[CW-1:0];
			nby_s1   <= nby[CW-1:0];
			nbz_s1   <= nbz[CW-1:0];
			nb_ok_s1 <= nb_ok;
		end
	end

	mbt_ram #(
		.DW    (1),
		.AW    (AW),
		.DEPTH (MDEP)
	) u_visit (
		.clk   (clk),
		.we    (visit_we),
		.waddr (visit_waddr),
		.wdata (visit_wdata),
		.raddr (visit_raddr),
		.rdata (visit_rdata)
	);

	mbt_ram #(
		.DW    (AW),
		.AW    (SAW),
		.DEPTH (CELLS)
	) u_trail (
		.clk   (clk),
		.we    (stack_we),
		.waddr (stack_waddr),
		.wdata (stack_wdata),
		.raddr (stack_raddr),
		.rdata (stack_rdata)
	);

	assign wx_wide  = {4'b0, wx_q};
	assign wy_wide  = {4'b0, wy_q};
	assign wz_wide  = {4'b0, wz_q};
	assign top_wide = {12'b0, top_q};

	always_comb begin
		res.outcome   = outcome_q;
		res.cell_x    = wx_wide[3:0];
		res.cell_y    = wy_wide[3:0];
		res.cell_z    = wz_wide[3:0];
		res.moved_dir = dir_q;
		res.depth     = top_wide[11:0];
	end

	// a push always enters a fresh cell, marking it in the same cycle
	a_push_marks: assert property (@(posedge clk) disable iff (!arst_n)
		stack_we |-> (visit_we && state_q == mbt_pkg::ST_CHECK))
		else $error("push without map write");

	// a pop takes exactly one cell off the trail
	a_pop_depth: assert property (@(posedge clk) disable iff (!arst_n)
		pop_go |=> (top_q == $past(top_dec)))
		else $error("pop depth mismatch");

	// the walker never leaves the coordinate space
	a_walker_range: assert property (@(posedge clk) disable iff (!arst_n)
		(XW'(wx_q) < XW'(MAX_DIM)) && (XW'(wy_q) < XW'(MAX_DIM))
		&& (XW'(wz_q) < XW'(MAX_DIM)))
		else $error("walker out of range");

	// the trail never grows past the cell count
	a_top_bound: assert property (@(posedge clk) disable iff (!arst_n)
		top_q <= TW'(CELLS))
		else $error("trail overflow");

endmodule

FILE: bench/maze_backtracker_3d_tb.sv
// self-checking testbench for the 3d maze backtracker: directed walks, then random walks in planned and random boxes
`timescale 1ns / 100ps

class maze_tracker;
	localparam int GRID = 16;

	bit               seen [GRID*GRID*GRID];
	logic [11:0]      trail [GRID*GRID*GRID];
	int               top;
	logic [3:0]       wx, wy, wz;
	logic [4:0]       bx, by, bz;
	mbt_pkg::result_t due [$];
	int               errors;

	function new();
		top = 0;
		wx = '0;
		wy = '0;
		wz = '0;
		bx = mbt_pkg::SIZE_RESET;
		by = mbt_pkg::SIZE_RESET;
		bz = mbt_pkg::SIZE_RESET;
		errors = 0;
	endfunction

	function void set_box(logic [4:0] x, logic [4:0] y, logic [4:0] z);
		bx = x;
		by = y;
		bz = z;
	endfunction

	function int extent(logic [4:0] s);
		return (s > GRID) ? GRID : int'(s);
	endfunction

	function bit neighbour_free(logic [2:0] d, output int nx, output int ny,
			output int nz);
		nx = wx;
		ny = wy;
		nz = wz;
		case (d)
			mbt_pkg::DIR_PZ: nz = nz + 1;
			mbt_pkg::DIR_NZ: nz = nz - 1;
			mbt_pkg::DIR_PY: ny = ny + 1;
			mbt_pkg::DIR_NY: ny = ny - 1;
			mbt_pkg::DIR_PX: nx = nx + 1;
			mbt_pkg::DIR_NX: nx = nx - 1;
			default: return 1'b0;
		endcase
		if (nx < 0 || ny < 0 || nz < 0)
			return 1'b0;
		if (nx >= extent(bx) || ny >= extent(by) || nz >= extent(bz))
			return 1'b0;
		return !seen[{nz[3:0], ny[3:0], nx[3:0]}];
	endfunction

	function void note_beat(logic op, logic [17:0] order);
		mbt_pkg::result_t r;
		int         tx, ty, tz, gx, gy, gz;
		logic [2:0] taken;
		logic [11:0] c;
		bit         found;
		found = 1'b0;
		taken = '0;
		gx = 0;
		gy = 0;
		gz = 0;
		if (op == mbt_pkg::OP_START) begin
			seen = '{default: 1'b0};
			top = 0;
			wx = '0;
			wy = '0;
			wz = '0;
			seen[0] = 1'b1;
			r.outcome = mbt_pkg::OUT_STARTED;
		end else begin
			for (int k = 0; k < mbt_pkg::NUM_TRIES; k++) begin
				if (!found && neighbour_free(order[3*k +: 3], tx, ty, tz)) begin
					found = 1'b1;
					taken = order[3*k +: 3];
					gx = tx;
					gy = ty;
					gz = tz;
				end
			end
			if (found && top < GRID*GRID*GRID) begin
				trail[top] = {wz, wy, wx};
				top++;
				wx = gx[3:0];
				wy = gy[3:0];
				wz = gz[3:0];
				seen[{wz, wy, wx}] = 1'b1;
				r.outcome = mbt_pkg::OUT_MOVED;
			end else if (top > 0) begin
				top--;
				c = trail[top];
				wx = c[3:0];
				wy = c[7:4];
				wz = c[11:8];
				taken = '0;
				r.outcome = mbt_pkg::OUT_BACK;
			end else begin
				taken = '0;
				r.outcome = mbt_pkg::OUT_FINISHED;
			end
		end
		r.cell_x = wx;
		r.cell_y = wy;
		r.cell_z = wz;
		r.moved_dir = (op == mbt_pkg::OP_START) ? 3'd0 : taken;
		r.depth = top[11:0];
		due.push_back(r);
	endfunction

	function void check_beat(logic [1:0] kind, logic [31:0] data);
		mbt_pkg::result_t want;
		if (due.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("unexpected result beat: outcome %0d data %h", kind, data);
			return;
		end
		want = due.pop_front();
		if (kind !== 2'(want.outcome) || data[3:0] !== want.cell_x
				|| data[7:4] !== want.cell_y || data[11:8] !== want.cell_z
				|| data[14:12] !== want.moved_dir || data[26:15] !== want.depth) begin
			errors++;
			if (errors <= 10) begin
				$display("mismatch: expected outcome %0d cell (%0d,%0d,%0d) dir %0d depth %0d",
					want.outcome, want.cell_x, want.cell_y, want.cell_z, want.moved_dir,
					want.depth);
				$display("          got      outcome %0d cell (%0d,%0d,%0d) dir %0d depth %0d",
					kind, data[3:0], data[7:4], data[11:8], data[14:12], data[26:15]);
			end
		end
	endfunction
endclass

module maze_backtracker_3d_tb;
	localparam logic [2:0] NO_DIR_LO = 3'd6;
	localparam logic [2:0] NO_DIR_HI = 3'd7;
	localparam int ITEMS     = 700;
	localparam int CALM_FROM = 640;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;   // try_first, try_second, try_third, try_fourth, try_fifth, try_sixth
	logic        s_tuser;   // op
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;   // cell_x, cell_y, cell_z, moved_dir, depth
	logic [1:0]  m_tuser;   // outcome
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [4:0]  cfg_data;

	maze_tracker tracker = new();
	int sent = 0;
	int gap_pct = 0;
	int stall_pct = 0;

	maze_backtracker_3d dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			tracker.check_beat(m_tuser, m_tdata);
	end

	// receiver stalls in bursts
	initial begin
		m_tready = 1'b1;
		forever begin
			@(posedge clk);
			if (sent < CALM_FROM && stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	initial begin
		#20_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	function automatic logic [17:0] pack_order(logic [2:0] a, logic [2:0] b, logic [2:0] c,
			logic [2:0] d, logic [2:0] e, logic [2:0] f);
		return {f, e, d, c, b, a};
	endfunction

	function automatic logic [17:0] random_order();
		logic [2:0] slot [6];
		logic [2:0] t;
		int j;
		if ($urandom_range(0, 4) == 0) begin
			for (int i = 0; i < 6; i++)
				slot[i] = 3'($urandom_range(0, 7));
		end else begin
			for (int i = 0; i < 6; i++)
				slot[i] = 3'(i);
			for (int i = 5; i > 0; i--) begin
				j = $urandom_range(0, i);
				t = slot[i];
				slot[i] = slot[j];
				slot[j] = t;
			end
		end
		return pack_order(slot[0], slot[1], slot[2], slot[3], slot[4], slot[5]);
	endfunction

	task automatic send_beat(input logic op, input logic [17:0] order);
		if (sent < CALM_FROM && gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {6'd0, order};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		tracker.note_beat(op, order);
		sent++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (tracker.due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_box(input logic [4:0] x, input logic [4:0] y, input logic [4:0] z);
		cfg_we <= 1'b1;
		cfg_index <= mbt_pkg::CFG_SIZE_X;
		cfg_data <= x;
		@(posedge clk);
		cfg_index <= mbt_pkg::CFG_SIZE_Y;
		cfg_data <= y;
		@(posedge clk);
		cfg_index <= mbt_pkg::CFG_SIZE_Z;
		cfg_data <= z;
		@(posedge clk);
		cfg_we <= 1'b0;
		tracker.set_box(x, y, z);
	endtask

	initial begin
		logic [4:0] plan [10][3];
		logic [4:0] px, py, pz;
		int phase, cells, steps;
		plan = '{'{16, 16, 16}, '{2, 3, 4}, '{16, 1, 1}, '{1, 16, 1}, '{1, 1, 16},
			'{31, 2, 2}, '{3, 3, 3}, '{2, 31, 1}, '{0, 4, 4}, '{4, 4, 4}};
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = mbt_pkg::OP_START;
		cfg_we = 1'b0;
		cfg_index = mbt_pkg::CFG_SIZE_X;
		cfg_data = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		gap_pct = 30;
		stall_pct = 30;
		// walking before any start, then back into the unmarked origin
		send_beat(mbt_pkg::OP_STEP, pack_order(mbt_pkg::DIR_PZ, mbt_pkg::DIR_NZ,
			mbt_pkg::DIR_PY, mbt_pkg::DIR_NY, mbt_pkg::DIR_PX, mbt_pkg::DIR_NX));
		send_beat(mbt_pkg::OP_STEP, pack_order(mbt_pkg::DIR_NZ, mbt_pkg::DIR_PZ,
			mbt_pkg::DIR_PY, mbt_pkg::DIR_NY, mbt_pkg::DIR_PX, mbt_pkg::DIR_NX));
		send_beat(mbt_pkg::OP_START, 18'h3FFFF);
		send_beat(mbt_pkg::OP_STEP, pack_order(NO_DIR_HI, NO_DIR_LO, NO_DIR_HI, NO_DIR_LO,
			NO_DIR_HI, NO_DIR_LO));
		send_beat(mbt_pkg::OP_STEP, pack_order(NO_DIR_HI, NO_DIR_LO, NO_DIR_HI, NO_DIR_LO,
			NO_DIR_HI, NO_DIR_LO));
		// only the last try is open
		send_beat(mbt_pkg::OP_STEP, pack_order(NO_DIR_HI, NO_DIR_LO, mbt_pkg::DIR_NZ,
			mbt_pkg::DIR_NY, mbt_pkg::DIR_NX, mbt_pkg::DIR_PX));
		send_beat(mbt_pkg::OP_STEP, pack_order(mbt_pkg::DIR_PX, mbt_pkg::DIR_NX,
			mbt_pkg::DIR_PY, mbt_pkg::DIR_NY, mbt_pkg::DIR_PZ, mbt_pkg::DIR_NZ));
		send_beat(mbt_pkg::OP_STEP, pack_order(mbt_pkg::DIR_PY, mbt_pkg::DIR_PX,
			mbt_pkg::DIR_NX, mbt_pkg::DIR_NY, mbt_pkg::DIR_PZ, mbt_pkg::DIR_NZ));
		send_beat(mbt_pkg::OP_STEP, pack_order(mbt_pkg::DIR_PZ, mbt_pkg::DIR_PX,
			mbt_pkg::DIR_NX, mbt_pkg::DIR_NY, mbt_pkg::DIR_PY, mbt_pkg::DIR_NZ));
		send_beat(mbt_pkg::OP_STEP, pack_order(NO_DIR_LO, NO_DIR_HI, NO_DIR_LO, NO_DIR_HI,
			NO_DIR_LO, NO_DIR_HI));
		send_beat(mbt_pkg::OP_STEP, 18'h0);
		// shrink the box under the walker
		drain();
		write_box(5'd1, 5'd1, 5'd1);
		repeat (4)
			send_beat(mbt_pkg::OP_STEP, pack_order(mbt_pkg::DIR_PZ, mbt_pkg::DIR_NZ,
				mbt_pkg::DIR_PY, mbt_pkg::DIR_NY, mbt_pkg::DIR_PX, mbt_pkg::DIR_NX));
		drain();
		write_box(5'd0, 5'd0, 5'd0);
		send_beat(mbt_pkg::OP_START, random_order());
		send_beat(mbt_pkg::OP_STEP, random_order());
		send_beat(mbt_pkg::OP_STEP, random_order());
		drain();

		phase = 0;
		while (sent < ITEMS) begin
			if (phase < 10) begin
				px = plan[phase][0];
				py = plan[phase][1];
				pz = plan[phase][2];
			end else begin
				px = 5'($urandom_range(1, 5));
				py = 5'($urandom_range(1, 5));
				pz = 5'($urandom_range(1, 5));
				if ($urandom_range(0, 3) == 0)
					py = 5'($urandom_range(0, 31));
			end
			cells = tracker.extent(px) * tracker.extent(py) * tracker.extent(pz);
			steps = (cells > 30) ? $urandom_range(40, 70) : 2 * cells + $urandom_range(1, 4);
			case ($urandom_range(0, 2))
				0: gap_pct = 0;
				1: gap_pct = 15;
				default: gap_pct = 40;
			endcase
			case ($urandom_range(0, 2))
				0: stall_pct = 0;
				1: stall_pct = 15;
				default: stall_pct = 40;
			endcase
			write_box(px, py, pz);
			if (phase == 0 || $urandom_range(0, 4) != 0)
				send_beat(mbt_pkg::OP_START, random_order());
			for (int i = 0; i < steps; i++) begin
				if ($urandom_range(0, 99) == 0)
					send_beat(mbt_pkg::OP_START, random_order());
				else
					send_beat(mbt_pkg::OP_STEP, random_order());
			end
			drain();
			phase++;
		end

		repeat (16) @(posedge clk);
		if (tracker.errors == 0 && tracker.due.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
